@@ rtl/ddo_pkg.sv @@
// shared types, constants and helpers for the differential drive odometry block
package ddo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W = $clog2(CORDIC_STEPS + 1);

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] RAD_TO_BAM = 34'sd683565276;

    localparam logic [1:0] REG_WHEEL_SIZE = 2'd0;
    localparam logic [1:0] REG_RADIUS_AXLE = 2'd1;
    localparam logic [1:0] REG_INVERSE_PERIOD = 2'd2;

    typedef struct packed {
        logic signed [31:0] right_angle;
        logic signed [31:0] left_angle;
    } ddo_req_t;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic [31:0]        heading;
        logic signed [31:0] step_x;
        logic signed [31:0] step_y;
        logic signed [31:0] step_heading;
    } ddo_rsp_t;

    function automatic logic signed [32:0] atan_lookup(input logic [4:0] i);
        logic signed [32:0] r;
        begin
            unique case (i)
                5'd0: r = 33'sh020000000;
                5'd1: r = 33'sh012E4051D;
                5'd2: r = 33'sh009FB385B;
                5'd3: r = 33'sh0051111D4;
                5'd4: r = 33'sh0028B0D43;
                5'd5: r = 33'sh00145D7E1;
                5'd6: r = 33'sh000A2F61E;
                5'd7: r = 33'sh000517C55;
                5'd8: r = 33'sh00028BE53;
                5'd9: r = 33'sh000145F2E;
                5'd10: r = 33'sh0000A2F98;
                5'd11: r = 33'sh0000517CC;
                5'd12: r = 33'sh000028BE6;
                5'd13: r = 33'sh0000145F3;
                5'd14: r = 33'sh00000A2F9;
                5'd15: r = 33'sh00000517C;
                5'd16: r = 33'sh0000028BE;
                5'd17: r = 33'sh00000145F;
                5'd18: r = 33'sh000000A2F;
                5'd19: r = 33'sh000000517;
                5'd20: r = 33'sh00000028B;
                5'd21: r = 33'sh000000145;
                5'd22: r = 33'sh0000000A2;
                5'd23: r = 33'sh000000051;
                5'd24: r = 33'sh000000028;
                5'd25: r = 33'sh000000014;
                5'd26: r = 33'sh00000000A;
                5'd27: r = 33'sh000000005;
                5'd28: r = 33'sh000000002;
                5'd29: r = 33'sh000000001;
                default: r = 33'sh000000000;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        begin
            if (v > 72'sd2147483647)
                r = 32'sh7FFFFFFF;
            else if (v < -72'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

@@ rtl/ddo_cordic.sv @@
// iterative rotation cordic giving cosine and sine of a binary angle
module ddo_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [33:0] cos_val,
    output logic signed [33:0] sin_val
);
    import ddo_pkg::*;

    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [32:0] z_reg, z_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic flip_reg, flip_next;
    logic [31:0] folded;
    logic signed [33:0] dx, dy;
    logic signed [32:0] at;

    assign folded = (angle[31:30] == 2'd1 || angle[31:30] == 2'd2)
                    ? angle + 32'h80000000 : angle;
    assign dx = y_reg >>> cnt_reg[4:0];
    assign dy = x_reg >>> cnt_reg[4:0];
    assign at = atan_lookup(cnt_reg[4:0]);

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        flip_next = flip_reg;
        if (start)
        begin
            x_next = CORDIC_GAIN;
            y_next = '0;
            z_next = {folded[31], folded};
            cnt_next = '0;
            busy_next = 1'b1;
            flip_next = (angle[31:30] == 2'd1 || angle[31:30] == 2'd2);
        end
        else if (busy_reg)
        begin
            if (!z_reg[32])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        cnt_reg <= cnt_next;
        flip_reg <= flip_next;
    end

    assign done = done_reg;
    assign cos_val = flip_reg ? -x_reg : x_reg;
    assign sin_val = flip_reg ? -y_reg : y_reg;
endmodule

@@ rtl/differential_drive_odometry.sv @@
// top level of the differential drive wheel odometry block
// each request runs from acceptance to result as follows: the accepting edge
// starts a 16 step iterative cordic (one rotation per cycle) on the heading
// while five multiplies run on one shared 40 by 32 bit multiplier; the cordic
// sets the pace, and the sequencer waits in its wait state until the last
// rotation is done, then two more multiplies give the increments and the done
// state commits the pose into the output register. the next request can be
// taken once the sequencer is back in idle, which it enters with the commit;
// a result the far side has not yet taken holds the commit of the following
// request. a finished result waits in the output register and the next
// request may be taken meanwhile. registers sit at byte address 0 (wheel
// radius), 4 (radius to axle ratio) and 8 (inverse period).
module differential_drive_odometry (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  ddo_pkg::ddo_req_t   req_data,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ddo_pkg::ddo_rsp_t   rsp_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ddo_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RR   = 4'd1;
    localparam logic [3:0] S_RL   = 4'd2;
    localparam logic [3:0] S_FWD  = 4'd3;
    localparam logic [3:0] S_TURN = 4'd4;
    localparam logic [3:0] S_DH   = 4'd5;
    localparam logic [3:0] S_CORD = 4'd6;
    localparam logic [3:0] S_DX   = 4'd7;
    localparam logic [3:0] S_DY   = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0] state_reg, state_next;

    // configuration registers
    logic [15:0] wheel_size_reg, radius_axle_reg, inverse_period_reg;

    // persistent odometry state
    logic signed [31:0] prev_r_reg, prev_l_reg, pos_x_reg, pos_y_reg;
    logic [31:0] theta_reg;

    // working registers of one request
    logic signed [31:0] new_r_reg, new_l_reg;
    logic signed [29:0] dr_reg, dl_reg;
    logic signed [38:0] rate_r_reg, rate_l_reg;
    logic signed [31:0] fwd_reg, turn_reg, dh_reg, dx_reg, dy_reg;
    logic cord_seen_reg;

    logic rsp_valid_reg;
    ddo_rsp_t rsp_reg;

    logic signed [39:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [71:0] prod;
    logic signed [39:0] rate_sum, rate_diff;

    logic cord_start, cord_done;
    logic signed [33:0] cos_val, sin_val;
    logic req_take, cfg_write, commit;
    logic signed [31:0] scaled_r, scaled_l;

    ddo_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start),
        .angle   (theta_reg),
        .done    (cord_done),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign req_take = req_valid && req_ready;
    assign cord_start = req_take;
    assign scaled_r = req_data.right_angle >>> 3;
    assign scaled_l = req_data.left_angle >>> 3;

    assign rate_sum = 40'(rate_r_reg) + 40'(rate_l_reg);
    assign rate_diff = 40'(rate_r_reg) - 40'(rate_l_reg);

    // commit once the previous result has left or is leaving now
    assign commit = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    // operand selection for the shared multiplier
    // cosine and sine stay within one in q2.30, so 32 bits hold them
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_RR:
            begin
                mul_a = 40'(dr_reg);
                mul_b = $signed({16'b0, inverse_period_reg});
            end
            S_RL:
            begin
                mul_a = 40'(dl_reg);
                mul_b = $signed({16'b0, inverse_period_reg});
            end
            S_FWD:
            begin
                mul_a = rate_sum;
                mul_b = $signed({16'b0, wheel_size_reg});
            end
            S_TURN:
            begin
                mul_a = rate_diff;
                mul_b = $signed({16'b0, radius_axle_reg});
            end
            S_DH:
            begin
                mul_a = 40'(turn_reg);
                mul_b = 32'(RAD_TO_BAM);
            end
            S_DX:
            begin
                mul_a = 40'(fwd_reg);
                mul_b = 32'(cos_val);
            end
            S_DY:
            begin
                mul_a = 40'(fwd_reg);
                mul_b = 32'(sin_val);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (req_take) state_next = S_RR;
            S_RR:   state_next = S_RL;
            S_RL:   state_next = S_FWD;
            S_FWD:  state_next = S_TURN;
            S_TURN: state_next = S_DH;
            S_DH:   state_next = S_CORD;
            S_CORD: if (cord_seen_reg || cord_done) state_next = S_DX;
            S_DX:   state_next = S_DY;
            S_DY:   state_next = S_DONE;
            S_DONE: if (!rsp_valid_reg || rsp_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wheel_size_reg <= 16'd256;
            radius_axle_reg <= 16'd320;
            inverse_period_reg <= 16'd256;
            prev_r_reg <= '0;
            prev_l_reg <= '0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            theta_reg <= '0;
            rsp_valid_reg <= 1'b0;
            cord_seen_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (paddr[3:2])
                    REG_WHEEL_SIZE:     wheel_size_reg <= pwdata[15:0];
                    REG_RADIUS_AXLE:    radius_axle_reg <= pwdata[15:0];
                    REG_INVERSE_PERIOD: inverse_period_reg <= pwdata[15:0];
                    default: ;
                endcase
            end
            // hold a cordic finish for the wait state; cleared when a request is taken
            if (req_take)
                cord_seen_reg <= 1'b0;
            else if (cord_done)
                cord_seen_reg <= 1'b1;
            if (commit)
            begin
                // commit the step and hand out the result
                prev_r_reg <= new_r_reg;
                prev_l_reg <= new_l_reg;
                pos_x_reg <= pos_x_reg + dx_reg;
                pos_y_reg <= pos_y_reg + dy_reg;
                theta_reg <= theta_reg + dh_reg;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            new_r_reg <= scaled_r;
            new_l_reg <= scaled_l;
            dr_reg <= 30'(scaled_r - prev_r_reg);
            dl_reg <= 30'(scaled_l - prev_l_reg);
        end
        unique case (state_reg)
            S_RR:   rate_r_reg <= 39'(prod >>> 8);
            S_RL:   rate_l_reg <= 39'(prod >>> 8);
            S_FWD:  fwd_reg <= sat32(prod >>> 9);
            S_TURN: turn_reg <= sat32(prod >>> 8);
            S_DH:   dh_reg <= 32'(prod >>> 16);
            S_DX:   dx_reg <= sat32(prod >>> 30);
            S_DY:   dy_reg <= sat32(prod >>> 30);
            default: ;
        endcase
        if (commit)
        begin
            rsp_reg.pose_x <= pos_x_reg + dx_reg;
            rsp_reg.pose_y <= pos_y_reg + dy_reg;
            rsp_reg.heading <= theta_reg + dh_reg;
            rsp_reg.step_x <= dx_reg;
            rsp_reg.step_y <= dy_reg;
            rsp_reg.step_heading <= dh_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data = rsp_reg;
    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_WHEEL_SIZE:     prdata = {16'b0, wheel_size_reg};
            REG_RADIUS_AXLE:    prdata = {16'b0, radius_axle_reg};
            REG_INVERSE_PERIOD: prdata = {16'b0, inverse_period_reg};
            default:            prdata = '0;
        endcase
    end
endmodule

@@ rtl/ddo_checker.sv @@
// port level checks of the odometry block and their binding
module ddo_port_checks (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input ddo_pkg::ddo_rsp_t rsp_data
);
    import ddo_pkg::*;

    logic [31:0] last_heading_reg;
    logic [31:0] last_x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_heading_reg <= '0;
            last_x_reg <= '0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            last_heading_reg <= rsp_data.heading;
            last_x_reg <= rsp_data.pose_x;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped before taken");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_heading: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.heading == last_heading_reg + rsp_data.step_heading)
        else $error("heading does not follow its increment");

    a_pose_x: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.pose_x == last_x_reg + rsp_data.step_x)
        else $error("x position does not follow its increment");
endmodule

bind differential_drive_odometry ddo_port_checks u_ddo_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

@@ bench/ddo_checker.sv @@
// checker for the odometry block: predicts each pose result and compares it
module ddo_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  ddo_pkg::ddo_req_t req_data,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  ddo_pkg::ddo_rsp_t rsp_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output int                fail_count,
    output int                poses_pending
);
    import ddo_pkg::*;

    logic [15:0] wheel_size;
    logic [15:0] radius_axle;
    logic [15:0] inverse_period;
    logic [31:0] last_right;
    logic [31:0] last_left;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] theta;

    ddo_rsp_t pose_queue[$];

    function automatic longint fshift(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint atan_step(input int i);
        longint t[32] = '{
            'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
            'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E, 'h000A2F98, 'h000517CC,
            'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
            'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051,
            'h00000028, 'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001,
            0, 0};
        return t[i];
    endfunction

    // odometry step: updates the pose state and returns the expected result
    function automatic ddo_rsp_t advance_pose(input ddo_req_t r);
        ddo_rsp_t o;
        longint nr, nl, rr, rl, fwd, turn, cx, sy, z, dx, dy, tx, ty;
        logic [31:0] folded, dh;
        logic flip;
        nr = fshift(longint'(r.right_angle), 3);
        nl = fshift(longint'(r.left_angle), 3);
        rr = fshift((nr - longint'($signed(last_right))) * longint'(inverse_period), 8);
        rl = fshift((nl - longint'($signed(last_left))) * longint'(inverse_period), 8);
        fwd = clamp32(fshift(longint'(wheel_size) * (rr + rl), 9));
        turn = clamp32(fshift(longint'(radius_axle) * (rr - rl), 8));
        // fold heading into the right half plane, flipping the vector
        flip = (theta[31:30] == 2'd1) || (theta[31:30] == 2'd2);
        folded = flip ? theta + 32'h80000000 : theta;
        z = longint'($signed(folded));
        cx = 652032874;
        sy = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++)
        begin
            tx = fshift(sy, i);
            ty = fshift(cx, i);
            if (z >= 0)
            begin
                cx -= tx; sy += ty; z -= atan_step(i);
            end
            else
            begin
                cx += tx; sy -= ty; z += atan_step(i);
            end
        end
        if (flip)
        begin
            cx = -cx; sy = -sy;
        end
        dx = clamp32(fshift(fwd * cx, 30));
        dy = clamp32(fshift(fwd * sy, 30));
        dh = 32'(fshift(turn * 683565276, 16));
        last_right = 32'(nr);
        last_left = 32'(nl);
        pos_x += 32'(dx);
        pos_y += 32'(dy);
        theta += dh;
        o.pose_x = pos_x;
        o.pose_y = pos_y;
        o.heading = theta;
        o.step_x = 32'(dx);
        o.step_y = 32'(dy);
        o.step_heading = dh;
        return o;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("ddo_checker: %s mismatch got %h want %h", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ddo_rsp_t w;
        if (!rst_n)
        begin
            wheel_size <= 16'd256;
            radius_axle <= 16'd320;
            inverse_period <= 16'd256;
            last_right = '0; last_left = '0;
            pos_x = '0; pos_y = '0; theta = '0;
            pose_queue.delete();
            poses_pending = 0;
            fail_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_WHEEL_SIZE:     wheel_size <= pwdata[15:0];
                    REG_RADIUS_AXLE:    radius_axle <= pwdata[15:0];
                    REG_INVERSE_PERIOD: inverse_period <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (req_valid && req_ready)
                pose_queue.push_back(advance_pose(req_data));
            if (rsp_valid && rsp_ready)
            begin
                if (pose_queue.size() == 0)
                begin
                    $display("ddo_checker: pose result with none expected");
                    fail_count++;
                end
                else
                begin
                    w = pose_queue.pop_front();
                    if (rsp_data.pose_x !== w.pose_x) report("pose_x", rsp_data.pose_x, w.pose_x);
                    if (rsp_data.pose_y !== w.pose_y) report("pose_y", rsp_data.pose_y, w.pose_y);
                    if (rsp_data.heading !== w.heading)
                        report("heading", rsp_data.heading, w.heading);
                    if (rsp_data.step_x !== w.step_x) report("step_x", rsp_data.step_x, w.step_x);
                    if (rsp_data.step_y !== w.step_y) report("step_y", rsp_data.step_y, w.step_y);
                    if (rsp_data.step_heading !== w.step_heading)
                        report("step_heading", rsp_data.step_heading, w.step_heading);
                end
            end
            poses_pending = pose_queue.size();
        end
    end
endmodule

@@ bench/tb_top.sv @@
// stimulus and verdict for the differential drive odometry bench
module tb_top;
    import ddo_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    ddo_req_t    req_data;
    logic        rsp_valid;
    logic        rsp_ready;
    ddo_rsp_t    rsp_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          poses_pending;
    int          cycle_count;
    // idling is switched off for a stretch in the middle of the random part
    bit          steady;

    differential_drive_odometry dut (.*);

    ddo_checker checker_i (
        .clk, .rst_n, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
        .rsp_data, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .fail_count, .poses_pending
    );

    // clock, period 4
    always
    begin
        clk = 1'b0; #2;
        clk = 1'b1; #2;
    end

    // run limit: 543 requests, plus stalls, many times over
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // result side stalls at random, about 18 percent of the time, except when steady
    always @(posedge clk)
    begin
        if (steady)
            rsp_ready <= 1'b1;
        else
            rsp_ready <= ($urandom_range(99) >= 18);
    end

    // one register write: setup phase, access phase, then psel is dropped and the bus idles
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= {16'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every pose result has come, then let the block settle
    task automatic drain;
        req_valid <= 1'b0;
        while (poses_pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // offer one request, hold it until the block takes it
    task automatic send_angles(input logic [31:0] right, input logic [31:0] left);
        if (!steady)
            while ($urandom_range(99) < 18)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        req_valid <= 1'b1;
        req_data.right_angle <= right;
        req_data.left_angle <= left;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // a random angle: mostly a small move from the last one, sometimes a larger move or anything
    function automatic logic [31:0] next_angle(input logic [31:0] last);
        case ($urandom_range(9))
            0: return $urandom;
            1: return last + 32'($signed($urandom_range(8000000)) - 4000000);
            default: return last + 32'($signed($urandom_range(40000)) - 20000);
        endcase
    endfunction

    initial
    begin
        logic [31:0] ra;
        logic [31:0] la;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        rsp_ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cycle_count = 0;
        steady = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes of the angles at reset settings
        send_angles(32'h7FFFFFFF, 32'h80000000);
        send_angles(32'h80000000, 32'h7FFFFFFF);
        send_angles(32'h0, 32'h0);
        send_angles(32'hFFFFFFFF, 32'h00000001);
        send_angles(32'h00010000, 32'h00010000);
        send_angles(32'h00100000, 32'h00080000);
        send_angles(32'h00100000, 32'h00080000);
        drain();

        // largest registers: saturating forward and turn terms and increments, heading wrap
        write_reg(REG_WHEEL_SIZE, 16'hFFFF);
        write_reg(REG_RADIUS_AXLE, 16'hFFFF);
        write_reg(REG_INVERSE_PERIOD, 16'hFFFF);
        send_angles(32'h7FFFFFFF, 32'h80000000);
        send_angles(32'h80000000, 32'h80000000);
        send_angles(32'h7FFFFFFF, 32'h7FFFFFFF);
        send_angles(32'h80000000, 32'h7FFFFFFF);
        send_angles(32'h12345678, 32'hEDCBA988);
        drain();

        // zero registers: no motion but the angles are still stored
        write_reg(REG_WHEEL_SIZE, 16'h0);
        write_reg(REG_RADIUS_AXLE, 16'h0);
        write_reg(REG_INVERSE_PERIOD, 16'h0);
        send_angles(32'h40000000, 32'hC0000000);
        send_angles(32'h00000000, 32'h00000000);
        drain();
        write_reg(2'd3, 16'h1234);  // no register here, write is dropped
        write_reg(REG_INVERSE_PERIOD, 16'h0100);
        send_angles(32'h00010000, 32'hFFFF0000);
        drain();

        // random phases with varied settings; one phase runs with no idling
        ra = '0; la = '0;
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(REG_WHEEL_SIZE, phase == 0 ? 16'h0100 : 16'($urandom));
            write_reg(REG_RADIUS_AXLE, phase == 0 ? 16'h0140 : 16'($urandom));
            write_reg(REG_INVERSE_PERIOD, phase == 0 ? 16'h0100 : 16'($urandom));
            steady = (phase == 3);
            for (int n = 0; n < 88; n++)
            begin
                ra = next_angle(ra);
                // a turn in place now and then, else an independent wheel
                la = ($urandom_range(4) == 0) ? -ra : next_angle(la);
                send_angles(ra, la);
            end
            drain();
        end

        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/ddo_pkg.sv
rtl/ddo_cordic.sv
rtl/differential_drive_odometry.sv
rtl/ddo_checker.sv
bench/ddo_checker.sv
bench/tb_top.sv
